// ----- rtl/ultrasonic_echo_ranger_unit_macros.svh -----
// assertion macros for the ultrasonic echo ranger
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define UER_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define UER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/uer_pkg.sv -----
// shared types and constants of the ultrasonic echo ranger
package uer_pkg;

    // ping sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_TRIG  = 5'b00010,
        PH_WAIT  = 5'b00100,
        PH_COUNT = 5'b01000,
        PH_HOLD  = 5'b10000
    } t_phase;

    // register indexes
    localparam logic REG_TRIGGER_WIDTH = 1'b0;
    localparam logic REG_HOLDOFF       = 1'b1;

    localparam logic [7:0]  TRIGGER_WIDTH_RST = 8'd20;
    localparam logic [15:0] HOLDOFF_RST       = 16'd50000;

    // distance = floor(sum * 16 / 103), saturated to 15 bits
    localparam int unsigned DIST_BITS    = 15;
    localparam logic [14:0] DIST_MAX     = 15'h7fff;
    localparam int unsigned DIST_SAT_SUM = 210944;
    localparam int unsigned DIV_IN_BITS  = 18;
    localparam int unsigned DIV_MUL_BITS = 23;
    localparam logic [22:0] DIV_MUL      = 23'd5212339;
    localparam int unsigned DIV_SHIFT    = 25;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [7:0]  trigger_width;
        logic [15:0] holdoff;
    } t_cfg;

endpackage

// ----- rtl/uer_cfg.sv -----
// apb register file for trigger width and hold-off
module uer_cfg
    import uer_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    logic w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[2];
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_width <= TRIGGER_WIDTH_RST;
            r_cfg.holdoff       <= HOLDOFF_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TRIGGER_WIDTH: r_cfg.trigger_width <= pwdata[7:0];
                REG_HOLDOFF:       r_cfg.holdoff       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_TRIGGER_WIDTH: prdata = {24'd0, r_cfg.trigger_width};
            REG_HOLDOFF:       prdata = {16'd0, r_cfg.holdoff};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/uer_dist.sv -----
// echo sum to q4 centimetres: reciprocal multiply with saturation
module uer_dist
    import uer_pkg::*;
#(
    parameter int unsigned SUM_BITS = 17
)
(
    input  logic [SUM_BITS-1:0]  i_sum,
    output logic [DIST_BITS-1:0] o_dist
);

    localparam int unsigned CW = (SUM_BITS > DIV_IN_BITS) ? SUM_BITS : DIV_IN_BITS;
    localparam int unsigned PW = DIV_IN_BITS + DIV_MUL_BITS;

    logic [CW-1:0] w_sum;
    logic          w_sat;
    logic [PW-1:0] w_prod;

    assign w_sum = CW'(i_sum);
    // anything at or above the saturation sum gives 32768 or more
    assign w_sat = (w_sum >= CW'(DIST_SAT_SUM));
    // below saturation the sum fits 18 bits; sum*m >> 25 equals sum*16/103
    assign w_prod = PW'(w_sum[DIV_IN_BITS-1:0]) * PW'(DIV_MUL);
    assign o_dist = w_sat ? DIST_MAX : w_prod[DIV_SHIFT +: DIST_BITS];

endmodule

// ----- rtl/ultrasonic_echo_ranger_unit.sv -----
// top level of the ultrasonic echo ranger: ping sequencer and result register
//
//  channel   direction  fields
//  s_axis    in         tdata: start_req, echo_level
//  m_axis    out        tdata: trigger_level, busy_res, distance_q4; tuser: distance_valid
//  apb       in/out     trigger_width_us at 0x0, holdoff_us at 0x4
//
// one item per clock while m_axis is not stalled: each item is one microsecond tick, one result per item
// an item's whole step is done in the cycle it is accepted, result registered
// s_axis_tready is high while the result register is empty or being taken
// reset brings the sequencer to idle, distance to zero and registers to defaults
// a stalled m_axis holds the result and the sequencer state together
`include "ultrasonic_echo_ranger_unit_macros.svh"

module ultrasonic_echo_ranger_unit
    import uer_pkg::*;
#(
    parameter int unsigned ECHO_COUNT_BITS = 16
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] start_req, [1] echo_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] trigger_level, [1] busy_res, [16:2] distance_q4
    output logic        m_axis_tuser,   // [0] distance_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned EB = ECHO_COUNT_BITS;
    localparam int unsigned SW = ECHO_COUNT_BITS + 1;
    localparam logic [EB-1:0] ECHO_MAX = {EB{1'b1}};

    t_cfg w_cfg;

    // sequencer state
    t_phase                 r_phase,      n_phase;
    logic [15:0]            r_ticks,      n_ticks;
    logic [EB-1:0]          r_echo_ticks, n_echo_ticks;
    logic [SW-1:0]          r_echo_sum,   n_echo_sum;
    logic                   r_sidx,       n_sidx;
    logic [DIST_BITS-1:0]   r_last_dist,  n_last_dist;

    // result register
    logic r_out_valid;
    logic r_out_trig,   n_trig;
    logic r_out_busy,   n_busy;
    logic r_out_dvalid, n_dvalid;

    logic                 w_accept;
    logic                 w_start;
    logic                 w_echo;
    logic [DIST_BITS-1:0] w_dist;

    uer_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    uer_dist #(
        .SUM_BITS (SW)
    ) u_dist (
        .i_sum  (r_echo_sum),
        .o_dist (w_dist)
    );

    // handshake
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_start       = s_axis_tdata[0];
    assign w_echo        = s_axis_tdata[1];

    // one tick of the ping sequencer
    always_comb begin
        n_phase      = r_phase;
        n_ticks      = r_ticks;
        n_echo_ticks = r_echo_ticks;
        n_echo_sum   = r_echo_sum;
        n_sidx       = r_sidx;
        n_last_dist  = r_last_dist;
        n_trig       = 1'b0;
        n_dvalid     = 1'b0;

        // start of a new two-ping reading
        if (n_phase == PH_IDLE && w_start) begin
            n_phase      = PH_TRIG;
            n_ticks      = 16'd0;
            n_echo_ticks = '0;
            n_echo_sum   = '0;
            n_sidx       = 1'b0;
        end

        case (n_phase)
            PH_HOLD: begin
                if (n_ticks < w_cfg.holdoff) begin
                    n_ticks = n_ticks + 16'd1;
                end else if (!n_sidx) begin
                    n_sidx  = 1'b1;
                    n_phase = PH_TRIG;
                    n_ticks = 16'd0;
                end else begin
                    n_last_dist = w_dist;
                    n_dvalid    = 1'b1;
                    n_phase     = PH_IDLE;
                    n_ticks     = 16'd0;
                end
            end
            PH_COUNT: begin
                if (w_echo) begin
                    if (n_echo_ticks != ECHO_MAX) begin
                        n_echo_ticks = n_echo_ticks + EB'(1);
                    end
                end else begin
                    n_echo_sum = n_echo_sum + SW'(n_echo_ticks);
                    n_phase    = PH_HOLD;
                    n_ticks    = 16'd0;
                end
            end
            PH_WAIT: begin
                if (w_echo) begin
                    n_echo_ticks = EB'(1);
                    n_phase      = PH_COUNT;
                end
            end
            default: ;
        endcase

        // trigger pulse, entered from idle or hold-off in the same tick
        if (n_phase == PH_TRIG) begin
            n_trig  = 1'b1;
            n_ticks = n_ticks + 16'd1;
            if (n_ticks >= 16'(w_cfg.trigger_width)) begin
                n_phase = PH_WAIT;
                n_ticks = 16'd0;
            end
        end

        n_busy = (n_phase != PH_IDLE);
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_ticks      <= 16'd0;
            r_echo_ticks <= '0;
            r_echo_sum   <= '0;
            r_sidx       <= 1'b0;
            r_last_dist  <= '0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_ticks      <= n_ticks;
            r_echo_ticks <= n_echo_ticks;
            r_echo_sum   <= n_echo_sum;
            r_sidx       <= n_sidx;
            r_last_dist  <= n_last_dist;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_trig   <= n_trig;
            r_out_busy   <= n_busy;
            r_out_dvalid <= n_dvalid;
        end
    end

    // distance comes straight from the last-distance register, which only
    // moves with an accepted item and so stays with the held result
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_last_dist, r_out_busy, r_out_trig};
    assign m_axis_tuser  = r_out_dvalid;

    // checks
    `UER_ASSERT_NOW(a_report_not_busy, i_clk, i_rst_n, r_out_valid && r_out_dvalid, !r_out_busy, "report item shows busy")
    `UER_ASSERT_NOW(a_trig_busy, i_clk, i_rst_n, r_out_valid && r_out_trig, r_out_busy && !r_out_dvalid, "trigger outside a reading")
    `UER_ASSERT_NEXT(a_dist_with_report, i_clk, i_rst_n, !w_accept || !n_dvalid, $stable(r_last_dist), "distance moved without a report")
    `UER_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_out_valid && !m_axis_tready, r_out_valid && $stable(r_phase), "stalled result dropped or state moved")

endmodule
